/* sv/fet_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_pkg
// Shared types, constants and helper functions of the Fourier excitation
// trajectory block: default sizes, register and state codes, multiplier
// handshake structs, the wide saturating add and the quarter-wave sine entry.
// ----------------------------------------------------------------------------
package fet_pkg;

  // default sizes
  localparam int unsigned HARMONIC_COUNT_DEF  = 10;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned FRACTION_BITS_DEF   = 16;

  // pi/2 in Q30 for the table series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // clamp bound of products and partial sums
  localparam logic signed [63:0] WIDE_LIMIT = 64'sh2000_0000_0000_0000;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PHASE_STEP,
    CFG_OMEGA,
    CFG_OMEGA_RECIP,
    CFG_POS_OFFSET
  } cfg_reg_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ORD_POSITION,
    ORD_VELOCITY,
    ORD_ACCEL,
    ORD_JERK,
    ORD_SNAP
  } order_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_FETCH,
    S_MUL_A,
    S_MUL_B,
    S_DIV,
    S_SQUARE,
    S_CUBE,
    S_MUL_S,
    S_DONE
  } fet_state_e;

  // multiplier request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] x;
    logic signed [63:0] y;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ovf;
    logic signed [63:0] q;
    logic [31:0]        lo;
  } mul_rsp_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic               ovf;
  } sat_t;

  // add with clamp to the wide bound
  function automatic sat_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    sat_t               r;
    s     = 65'(a) + 65'(b);
    r.ovf = 1'b0;
    r.sum = s[63:0];
    if (s > 65'(WIDE_LIMIT)) begin
      r.sum = WIDE_LIMIT;
      r.ovf = 1'b1;
    end else if (s < -65'(WIDE_LIMIT)) begin
      r.sum = -WIDE_LIMIT;
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // quarter-wave sine entry j, series in Q30, rounded to fb fraction bits
  function automatic longint quarter_sine(int j, int stb, int fb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (HALF_PI_Q30 * 64'(j)) >> stb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + (longint'(1) << (29 - fb))) >>> (30 - fb);
    if (v > (longint'(1) << fb)) v = longint'(1) << fb;
    return v;
  endfunction

endpackage

/* sv/fet_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fet_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fet_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_mul
// Sequential signed fixed-point multiplier: sign-magnitude 64x64 product
// built from four 32x32 partial products, truncated toward zero after the
// fraction shift and clamped to the wide bound.
// ----------------------------------------------------------------------------
module fet_mul
  import fet_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic         busy_q;
  logic         done_q;
  logic [2:0]   step_q;
  logic         pp_vld_q;
  logic [1:0]   pp_sh_q;
  logic [63:0]  pp_q;
  logic [127:0] prod_q;
  logic [63:0]  mx_q;
  logic [63:0]  my_q;
  logic         neg_q;

  logic [31:0]  half_x;
  logic [31:0]  half_y;
  logic [127:0] pp_shifted;
  logic [63:0]  q_mag;
  logic         over;
  logic [63:0]  q_clamped;
  logic         start;

  assign start  = req_i.start && !busy_q;
  assign half_x = step_q[1] ? mx_q[63:32] : mx_q[31:0];
  assign half_y = step_q[0] ? my_q[63:32] : my_q[31:0];

  // place a partial product at its weight
  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
      default: pp_shifted = {pp_q, 64'd0};
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        pp_vld_q <= 1'b0;
      end else if (busy_q) begin
        if (step_q != LAST_STEP) begin
          step_q   <= step_q + 3'd1;
          pp_vld_q <= 1'b1;
        end else begin
          pp_vld_q <= 1'b0;
          busy_q   <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // operands, partial products and accumulation
  always_ff @(posedge clk_i) begin
    if (start) begin
      mx_q   <= req_i.x[63] ? 64'(-req_i.x) : 64'(req_i.x);
      my_q   <= req_i.y[63] ? 64'(-req_i.y) : 64'(req_i.y);
      neg_q  <= req_i.x[63] ^ req_i.y[63];
      prod_q <= '0;
    end else if (busy_q) begin
      if (step_q != LAST_STEP) begin
        pp_q    <= 64'(half_x) * 64'(half_y);
        pp_sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (pp_vld_q) begin
        prod_q <= prod_q + pp_shifted;
      end
    end
  end

  // fraction shift, clamp and sign
  assign q_mag     = prod_q[FRACTION_BITS+63:FRACTION_BITS];
  assign over      = (|prod_q[127:64+FRACTION_BITS]) || (q_mag > 64'(WIDE_LIMIT));
  assign q_clamped = over ? 64'(WIDE_LIMIT) : q_mag;

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = over;
  assign rsp_o.q    = neg_q ? -$signed(q_clamped) : $signed(q_clamped);
  assign rsp_o.lo   = prod_q[31:0];

endmodule

/* sv/fourier_excitation_trajectory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourier_excitation_trajectory
// Evaluates a Fourier excitation trajectory or one of its first four
// derivatives at a sample index, from per-harmonic coefficients in a RAM.
// ----------------------------------------------------------------------------
// Items with tuser 0 load the a and b coefficients of one harmonic (slots
// beyond the harmonic count are dropped). Items with tuser 1 evaluate the
// trajectory of the requested order and return one result (orders above
// four give none). Evaluation is sequential, one harmonic at a time, with
// every product made on one shared sequential multiplier built from 32x32
// partial products. Each harmonic takes three products for position,
// velocity and acceleration, four for the third and five for the fourth
// derivative; for position the bit-serial 1/k divider is the limit. The
// next item is taken once the result sits in the output register.
// ----------------------------------------------------------------------------
module fourier_excitation_trajectory
  import fet_pkg::*;
#(
  parameter int unsigned HARMONIC_COUNT  = HARMONIC_COUNT_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // harmonic[3:0], coef_a[35:4], coef_b[67:36], sample_index[99:68],
  // order[102:100], zero pad[103]
  input  logic [103:0]          s_axis_tdata,
  // action
  input  logic                  s_axis_tuser,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // value[31:0]
  output logic [31:0]           m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser
);

  localparam int unsigned IDX_W  = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
  localparam int unsigned K_W    = $clog2(HARMONIC_COUNT + 1);
  localparam int unsigned WK_W   = 31 + K_W;
  localparam int unsigned TQ     = 1 << SINE_TABLE_BITS;
  localparam int unsigned TW     = FRACTION_BITS + 1;
  localparam int unsigned TI     = SINE_TABLE_BITS + 1;
  localparam int unsigned SV_W   = FRACTION_BITS + 2;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [4:0]  DIV_LAST     = 5'd30;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

  // ---------------------------------------------------------------- input fields
  logic [3:0]  in_harmonic;
  logic [31:0] in_coef_a;
  logic [31:0] in_coef_b;
  logic [31:0] in_sample;
  logic [2:0]  in_order;
  logic        s_fire;

  assign in_harmonic = s_axis_tdata[3:0];
  assign in_coef_a   = s_axis_tdata[35:4];
  assign in_coef_b   = s_axis_tdata[67:36];
  assign in_sample   = s_axis_tdata[99:68];
  assign in_order    = s_axis_tdata[102:100];
  assign s_fire      = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- registers
  logic [31:0]        phase_step_q;
  logic [30:0]        omega_q;
  logic [30:0]        omega_recip_q;
  logic signed [31:0] offset_q;

  fet_state_e state_q, state_d;

  logic [HARMONIC_COUNT-1:0] vld_q;
  logic                      ent_vld_q;
  logic [31:0]               n_q;
  logic [2:0]                order_q;
  logic [31:0]               base_q;
  logic [31:0]               theta_q;
  logic [K_W-1:0]            k_q;
  logic [WK_W-1:0]           wk_q;
  logic [TW-1:0]             sin_mag_q;
  logic                      sin_neg_q;
  logic [TW-1:0]             cos_mag_q;
  logic                      cos_neg_q;
  logic signed [63:0]        inner_q;
  logic signed [63:0]        scale_q;
  logic signed [63:0]        acc_q;
  logic                      ovf_q;
  logic                      mul_issued_q;

  logic                      div_busy_q;
  logic [4:0]                div_cnt_q;
  logic [30:0]               div_quo_q;
  logic [K_W-1:0]            div_rem_q;

  logic                      m_valid_q;
  logic [31:0]               m_data_q;
  logic                      m_sat_q;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      omega_q       <= 31'(ONE_Q);
      omega_recip_q <= 31'(ONE_Q);
      offset_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_PHASE_STEP:  phase_step_q  <= cfg_wdata_i;
        CFG_OMEGA:       omega_q       <= cfg_wdata_i[30:0];
        CFG_OMEGA_RECIP: omega_recip_q <= cfg_wdata_i[30:0];
        CFG_POS_OFFSET:  offset_q      <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- coefficient ram
  logic             ram_we;
  logic             slot_ok;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic             ram_re;
  logic [63:0]      ram_rdata;

  assign slot_ok   = 32'(in_harmonic) < HARMONIC_COUNT;
  assign ram_we    = s_fire && (s_axis_tuser == ACT_WRITE) && slot_ok;
  assign ram_waddr = IDX_W'(in_harmonic);
  assign ram_raddr = IDX_W'(k_q - K_W'(1));
  assign ram_re    = (state_q == S_FETCH);

  fet_ram #(
    .WIDTH (64),
    .DEPTH (HARMONIC_COUNT)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_coef_b, in_coef_a}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // written-entry flags, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- sine table
  logic [TW-1:0] sine_rom [TQ+1];

  for (genvar j = 0; j <= TQ; j++) begin : g_rom
    localparam logic [TW-1:0] ENTRY = TW'(quarter_sine(j, SINE_TABLE_BITS, FRACTION_BITS));
    assign sine_rom[j] = ENTRY;
  end

  logic [31:0]                theta_c;
  logic [SINE_TABLE_BITS-1:0] s_idx;
  logic [SINE_TABLE_BITS-1:0] c_idx;
  logic [TI-1:0]              s_ridx;
  logic [TI-1:0]              c_ridx;

  // quadrant fold of the phase
  assign theta_c = theta_q + QUARTER_TURN;
  assign s_idx   = theta_q[29 -: SINE_TABLE_BITS];
  assign c_idx   = theta_c[29 -: SINE_TABLE_BITS];
  assign s_ridx  = theta_q[30] ? (TI'(TQ) - {1'b0, s_idx}) : {1'b0, s_idx};
  assign c_ridx  = theta_c[30] ? (TI'(TQ) - {1'b0, c_idx}) : {1'b0, c_idx};

  // ---------------------------------------------------------------- operand select
  logic signed [SV_W-1:0] sin_val;
  logic signed [SV_W-1:0] cos_val;
  logic signed [SV_W-1:0] x_sel;
  logic signed [SV_W-1:0] y_sel;
  logic signed [63:0]     a_val;
  logic signed [63:0]     b_val;
  logic signed [63:0]     wk_val;

  assign sin_val = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
  assign cos_val = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});
  assign a_val   = ent_vld_q ? 64'($signed(ram_rdata[31:0])) : '0;
  assign b_val   = ent_vld_q ? 64'($signed(ram_rdata[63:32])) : '0;
  assign wk_val  = {{(64-WK_W){1'b0}}, wk_q};

  // derivative order rotates the sine and cosine terms
  always_comb begin
    case (order_q)
      ORD_VELOCITY: begin
        x_sel = cos_val;
        y_sel = sin_val;
      end
      ORD_ACCEL: begin
        x_sel = -sin_val;
        y_sel = cos_val;
      end
      ORD_JERK: begin
        x_sel = -cos_val;
        y_sel = -sin_val;
      end
      default: begin
        x_sel = sin_val;
        y_sel = -cos_val;
      end
    endcase
  end

  // ---------------------------------------------------------------- multiplier
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     mul_state;

  always_comb begin
    mul_state = 1'b1;
    mul_req.x = '0;
    mul_req.y = '0;
    case (state_q)
      S_BASE: begin
        mul_req.x = {32'd0, n_q};
        mul_req.y = {32'd0, phase_step_q};
      end
      S_MUL_A: begin
        mul_req.x = a_val;
        mul_req.y = 64'(x_sel);
      end
      S_MUL_B: begin
        mul_req.x = b_val;
        mul_req.y = 64'(y_sel);
      end
      S_SQUARE: begin
        mul_req.x = wk_val;
        mul_req.y = wk_val;
      end
      S_CUBE: begin
        mul_req.x = scale_q;
        mul_req.y = wk_val;
      end
      S_MUL_S: begin
        mul_req.x = scale_q;
        mul_req.y = inner_q;
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !mul_issued_q;
  end

  fet_mul #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_issued_q <= 1'b0;
    end else if (mul_req.start) begin
      mul_issued_q <= 1'b1;
    end else if (mul_rsp.done) begin
      mul_issued_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- next state
  logic out_free;
  logic last_k;

  assign out_free = !m_valid_q || m_axis_tready;
  assign last_k   = (32'(k_q) == HARMONIC_COUNT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_fire && (s_axis_tuser == ACT_EVAL) && (in_order <= ORD_SNAP)) state_d = S_BASE;
      end
      S_BASE:  if (mul_rsp.done) state_d = S_FETCH;
      S_FETCH: state_d = S_MUL_A;
      S_MUL_A: if (mul_rsp.done) state_d = S_MUL_B;
      S_MUL_B: begin
        if (mul_rsp.done) begin
          case (order_q)
            ORD_POSITION:           state_d = S_DIV;
            ORD_VELOCITY, ORD_ACCEL: state_d = S_MUL_S;
            default:                state_d = S_SQUARE;
          endcase
        end
      end
      S_DIV:    if (!div_busy_q) state_d = S_MUL_S;
      S_SQUARE: if (mul_rsp.done) state_d = (order_q == ORD_JERK) ? S_MUL_S : S_CUBE;
      S_CUBE:   if (mul_rsp.done) state_d = S_MUL_S;
      S_MUL_S:  if (mul_rsp.done) state_d = last_k ? S_DONE : S_FETCH;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // ---------------------------------------------------------------- harmonic datapath
  sat_t inner_sat;
  sat_t acc_sat;

  assign inner_sat = sat_add(inner_q, mul_rsp.q);
  assign acc_sat   = sat_add(acc_q, mul_rsp.q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          n_q     <= in_sample;
          order_q <= in_order;
        end
      end
      S_BASE: begin
        if (mul_rsp.done) begin
          base_q  <= mul_rsp.lo;
          theta_q <= mul_rsp.lo;
          k_q     <= K_W'(1);
          wk_q    <= WK_W'(omega_q);
          acc_q   <= '0;
          ovf_q   <= 1'b0;
        end
      end
      S_FETCH: begin
        ent_vld_q <= vld_q[ram_raddr];
        sin_mag_q <= sine_rom[s_ridx];
        sin_neg_q <= theta_q[31];
        cos_mag_q <= sine_rom[c_ridx];
        cos_neg_q <= theta_c[31];
      end
      S_MUL_A: begin
        if (mul_rsp.done) begin
          inner_q <= mul_rsp.q;
          ovf_q   <= ovf_q | mul_rsp.ovf;
        end
      end
      S_MUL_B: begin
        if (mul_rsp.done) begin
          inner_q <= inner_sat.sum;
          ovf_q   <= ovf_q | mul_rsp.ovf | inner_sat.ovf;
          if (order_q == ORD_VELOCITY) scale_q <= ONE_Q;
          else                         scale_q <= wk_val;
        end
      end
      S_DIV: begin
        if (!div_busy_q) scale_q <= {33'd0, div_quo_q};
      end
      S_SQUARE, S_CUBE: begin
        if (mul_rsp.done) begin
          scale_q <= mul_rsp.q;
          ovf_q   <= ovf_q | mul_rsp.ovf;
        end
      end
      S_MUL_S: begin
        if (mul_rsp.done) begin
          acc_q   <= acc_sat.sum;
          ovf_q   <= ovf_q | mul_rsp.ovf | acc_sat.ovf;
          k_q     <= k_q + K_W'(1);
          theta_q <= theta_q + base_q;
          wk_q    <= wk_q + WK_W'(omega_q);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- 1/k divider
  logic [K_W:0] div_trial;
  logic         div_ge;

  assign div_trial = {div_rem_q, div_quo_q[30]};
  assign div_ge    = div_trial >= {1'b0, k_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if ((state_q == S_FETCH) && (order_q == ORD_POSITION)) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 5'd1;
      if (div_cnt_q == DIV_LAST) div_busy_q <= 1'b0;
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FETCH) && (order_q == ORD_POSITION)) begin
      div_quo_q <= omega_recip_q;
      div_rem_q <= '0;
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? K_W'(div_trial - {1'b0, k_q}) : K_W'(div_trial);
      div_quo_q <= {div_quo_q[29:0], div_ge};
    end
  end

  // ---------------------------------------------------------------- final sum and output
  sat_t               fin_sat;
  logic signed [63:0] fin_sum;
  logic               fin_ovf;
  logic [31:0]        out_value;
  logic               out_sat;

  assign fin_sat = sat_add(acc_q, 64'(offset_q));

  always_comb begin
    if (order_q == ORD_POSITION) begin
      fin_sum = fin_sat.sum;
      fin_ovf = ovf_q | fin_sat.ovf;
    end else begin
      fin_sum = acc_q;
      fin_ovf = ovf_q;
    end
    out_value = fin_sum[31:0];
    out_sat   = fin_ovf;
    if (fin_sum > OUT_MAX) begin
      out_value = OUT_MAX[31:0];
      out_sat   = 1'b1;
    end else if (fin_sum < OUT_MIN) begin
      out_value = OUT_MIN[31:0];
      out_sat   = 1'b1;
    end
  end

  logic out_load;

  assign out_load = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_value;
      m_sat_q  <= out_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_sat_q;

  // ---------------------------------------------------------------- assertions
  a_mul_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_div_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_S) && (order_q == ORD_POSITION) |-> !div_busy_q)
    else $error("position scale used before divider finished");

  a_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> (k_q != '0) && (32'(k_q) <= HARMONIC_COUNT))
    else $error("harmonic counter out of range");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ram_we)
    else $error("coefficient write during evaluation");

endmodule
